/* rtl/wtsp_pkg.sv */
// ----------------------------------------------------------------------------
// wtsp_pkg: shared types and constants for the world-to-screen projection
// Fixed-point widths, request codes, register indexes and payload words.
// ----------------------------------------------------------------------------
package wtsp_pkg;

  // Fraction bits of every fixed-point value
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int SCALE_W   = 14;
  localparam int SCREEN_W  = 30;
  localparam int ENTRY_N   = 16;
  localparam int ENTRY_W   = 4;

  // Homogeneous sum: three floored products plus an entry, two guard bits
  localparam int H_W    = 2 * COORD_W + 2 - FRAC_BITS;
  localparam int NUM_W  = H_W + 1;
  localparam int PROD_W = NUM_W + SCALE_W;
  // Quotient does not exceed scale * 2^FRAC_BITS for a visible point
  localparam int Q_W    = SCALE_W + FRAC_BITS;
  localparam int SAT_W  = Q_W + SCREEN_W;

  localparam logic [SCREEN_W-1:0] SCREEN_MAX = SCREEN_W'(1) << (SCREEN_W - 1);

  // Input queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // Request codes
  localparam logic REQ_TRANSFORM = 1'b0;
  localparam logic REQ_LOAD      = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

  localparam logic [SCALE_W-1:0] WIDTH_RST  = SCALE_W'(1920);
  localparam logic [SCALE_W-1:0] HEIGHT_RST = SCALE_W'(1080);

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [ENTRY_W-1:0]        entry_index;
    logic signed [COORD_W-1:0] entry_value;
  } in_word_t;

  typedef struct packed {
    logic                visible;
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
  } out_word_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic     is_load;
    in_word_t word;
  } front_item_t;

  typedef struct packed {
    logic              vis;
    logic [PROD_W-1:0] px;
    logic [PROD_W-1:0] py;
    logic [NUM_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic           vis;
    logic [Q_W-1:0] qx;
    logic [Q_W-1:0] qy;
  } div_rsp_t;

endpackage

/* rtl/wtsp_front.sv */
// ----------------------------------------------------------------------------
// wtsp_front: input acceptance and classification
// Tags each word as a matrix load or a transform and queues it for the back.
// ----------------------------------------------------------------------------
module wtsp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wtsp_pkg::in_word_t    in_data,
  input  logic                  pop,
  output logic                  q_valid,
  output wtsp_pkg::front_item_t q_item
);
  import wtsp_pkg::*;

  front_item_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push;
  logic              do_pop;

  // Hold the input while the queue is full
  assign in_stall = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign do_pop   = pop && q_valid;
  assign q_item   = mem[rptr_r];

  // Advance pointers and count
  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Classify and store the word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r].is_load <= (in_data.req_type == REQ_LOAD);
      mem[wptr_r].word    <= in_data;
    end
  end

endmodule

/* rtl/wtsp_div.sv */
// ----------------------------------------------------------------------------
// wtsp_div: pipelined restoring divider for both screen coordinates
// One quotient bit per stage for x and y against a shared divisor.
// ----------------------------------------------------------------------------
module wtsp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               req_vld,
  input  wtsp_pkg::div_req_t req,
  output logic               rsp_vld,
  output wtsp_pkg::div_rsp_t rsp
);
  import wtsp_pkg::*;

  logic             vld_r  [Q_W];
  logic             vis_r  [Q_W];
  logic [NUM_W-1:0] den_r  [Q_W];
  logic [NUM_W-1:0] remx_r [Q_W];
  logic [NUM_W-1:0] remy_r [Q_W];
  logic [Q_W-1:0]   lox_r  [Q_W];
  logic [Q_W-1:0]   loy_r  [Q_W];
  logic [Q_W-1:0]   qx_r   [Q_W];
  logic [Q_W-1:0]   qy_r   [Q_W];

  // One restoring step: returns next remainder and quotient bit
  function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
                                               input logic b,
                                               input logic [NUM_W-1:0] den);
    logic [NUM_W:0] trial;
    logic [NUM_W:0] diff;
    trial = {rem, b};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {diff[NUM_W-1:0], 1'b1};
    end
    return {trial[NUM_W-1:0], 1'b0};
  endfunction

  genvar k;
  generate
    for (k = 0; k < Q_W; k++) begin : g_stage
      logic             vld_in, vis_in;
      logic [NUM_W-1:0] den_in, remx_in, remy_in;
      logic [Q_W-1:0]   lox_in, loy_in, qx_in, qy_in;
      logic [NUM_W:0]   sx, sy;

      // Select the stage input
      if (k == 0) begin : g_first
        always_comb begin
          vld_in  = req_vld;
          vis_in  = req.vis;
          den_in  = req.den;
          remx_in = req.px[PROD_W-1:SCALE_W];
          remy_in = req.py[PROD_W-1:SCALE_W];
          lox_in  = {req.px[SCALE_W-1:0], FRAC_BITS'(0)};
          loy_in  = {req.py[SCALE_W-1:0], FRAC_BITS'(0)};
          qx_in   = '0;
          qy_in   = '0;
        end
      end else begin : g_next
        always_comb begin
          vld_in  = vld_r[k-1];
          vis_in  = vis_r[k-1];
          den_in  = den_r[k-1];
          remx_in = remx_r[k-1];
          remy_in = remy_r[k-1];
          lox_in  = lox_r[k-1];
          loy_in  = loy_r[k-1];
          qx_in   = qx_r[k-1];
          qy_in   = qy_r[k-1];
        end
      end

      assign sx = div_step(remx_in, lox_in[Q_W-1], den_in);
      assign sy = div_step(remy_in, loy_in[Q_W-1], den_in);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          vis_r[k]  <= vis_in;
          den_r[k]  <= den_in;
          remx_r[k] <= sx[NUM_W:1];
          remy_r[k] <= sy[NUM_W:1];
          lox_r[k]  <= lox_in << 1;
          loy_r[k]  <= loy_in << 1;
          qx_r[k]   <= {qx_in[Q_W-2:0], sx[0]};
          qy_r[k]   <= {qy_in[Q_W-2:0], sy[0]};
        end
      end
    end
  endgenerate

  assign rsp_vld = vld_r[Q_W-1];
  assign rsp.vis = vis_r[Q_W-1];
  assign rsp.qx  = qx_r[Q_W-1];
  assign rsp.qy  = qy_r[Q_W-1];

endmodule

/* rtl/wtsp_back.sv */
// ----------------------------------------------------------------------------
// wtsp_back: matrix store, transform, clip test and viewport mapping
// Applies loads in order and runs transforms through a stalled pipeline.
// ----------------------------------------------------------------------------
module wtsp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  wtsp_pkg::front_item_t          q_item,
  output logic                           pop,
  input  logic [wtsp_pkg::SCALE_W-1:0]   scr_width,
  input  logic [wtsp_pkg::SCALE_W-1:0]   scr_height,
  output logic                           out_valid,
  input  logic                           out_stall,
  output wtsp_pkg::out_word_t            out_data
);
  import wtsp_pkg::*;

  logic                      en;
  logic signed [COORD_W-1:0] mat_r [ENTRY_N];
  logic signed [COORD_W-1:0] pt [3];

  logic                      s1_vld_r;
  logic signed [2*COORD_W-1:0] prod_r [4][3];
  logic signed [COORD_W-1:0] bias_r [4];

  logic                      s2_vld_r;
  logic signed [H_W-1:0]     h_r [4];
  logic signed [H_W-1:0]     h_nxt [4];

  logic                      s3_vld_r, s3_vis_r;
  logic [NUM_W-1:0]          numx_r, numy_r, den_r;
  logic                      vis_nxt;
  logic [NUM_W-1:0]          numx_nxt, numy_nxt, den_nxt;
  logic [H_W-1:0]            ax, ay, az, aw;
  logic signed [H_W-1:0]     hxn, hyn;

  logic                      s4_vld_r;
  div_req_t                  s4_req_r;

  logic                      dv_vld;
  div_rsp_t                  dv_rsp;

  logic                      out_valid_r;
  out_word_t                 out_data_r;
  out_word_t                 out_nxt;

  // Advance whenever the output register is free or being taken
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && q_valid;

  assign pt[0] = q_item.word.point_x;
  assign pt[1] = q_item.word.point_y;
  assign pt[2] = q_item.word.point_z;

  // Write matrix entries in queue order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRY_N; i++) begin
        mat_r[i] <= '0;
      end
    end else if (pop && q_item.is_load) begin
      mat_r[q_item.word.entry_index] <= q_item.word.entry_value;
    end
  end

  // Stage 1: products of entries and coordinates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= pop && !q_item.is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= mat_r[r*4+c] * pt[c];
        end
        bias_r[r] <= mat_r[r*4+3];
      end
    end
  end

  // Stage 2: floor each product and sum the row
  always_comb begin
    logic signed [2*COORD_W-1:0] sh;
    for (int r = 0; r < 4; r++) begin
      h_nxt[r] = H_W'(bias_r[r]);
      for (int c = 0; c < 3; c++) begin
        sh       = prod_r[r][c] >>> FRAC_BITS;
        h_nxt[r] = h_nxt[r] + sh[H_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        h_r[r] <= h_nxt[r];
      end
    end
  end

  // Stage 3: clip test, make w positive, form numerators and divisor
  always_comb begin
    ax       = h_r[0][H_W-1] ? H_W'(-h_r[0]) : H_W'(h_r[0]);
    ay       = h_r[1][H_W-1] ? H_W'(-h_r[1]) : H_W'(h_r[1]);
    az       = h_r[2][H_W-1] ? H_W'(-h_r[2]) : H_W'(h_r[2]);
    aw       = h_r[3][H_W-1] ? H_W'(-h_r[3]) : H_W'(h_r[3]);
    vis_nxt  = (h_r[3] != '0) && (ax <= aw) && (ay <= aw) && (az <= aw);
    hxn      = h_r[3][H_W-1] ? -h_r[0] : h_r[0];
    hyn      = h_r[3][H_W-1] ? -h_r[1] : h_r[1];
    numx_nxt = NUM_W'(hxn) + {1'b0, aw};
    numy_nxt = {1'b0, aw} - NUM_W'(hyn);
    den_nxt  = {aw, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_vis_r <= vis_nxt;
      numx_r   <= numx_nxt;
      numy_r   <= numy_nxt;
      den_r    <= den_nxt;
    end
  end

  // Stage 4: scale numerators by the screen size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_req_r.vis <= s3_vis_r;
      s4_req_r.px  <= PROD_W'(numx_r) * PROD_W'(scr_width);
      s4_req_r.py  <= PROD_W'(numy_r) * PROD_W'(scr_height);
      s4_req_r.den <= den_r;
    end
  end

  wtsp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .req_vld (s4_vld_r),
    .req     (s4_req_r),
    .rsp_vld (dv_vld),
    .rsp     (dv_rsp)
  );

  // Saturate and drop coordinates of invisible points
  always_comb begin
    out_nxt.visible  = dv_rsp.vis;
    out_nxt.screen_x = '0;
    out_nxt.screen_y = '0;
    if (dv_rsp.vis) begin
      out_nxt.screen_x = (SAT_W'(dv_rsp.qx) > SAT_W'(SCREEN_MAX)) ? SCREEN_MAX
                                                                   : SCREEN_W'(dv_rsp.qx);
      out_nxt.screen_y = (SAT_W'(dv_rsp.qy) > SAT_W'(SCREEN_MAX)) ? SCREEN_MAX
                                                                   : SCREEN_W'(dv_rsp.qy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An invisible point carries zero coordinates
  a_invis_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.visible |->
      out_data_r.screen_x == '0 && out_data_r.screen_y == '0)
    else $error("invisible word with nonzero coordinates");

  // Coordinates never pass the saturation limit
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.screen_x <= SCREEN_MAX && out_data_r.screen_y <= SCREEN_MAX)
    else $error("screen coordinate above limit");

  // A stalled pipeline neither pops nor moves
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> !pop ##1 ($stable(s1_vld_r) && $stable(s4_vld_r)))
    else $error("pipeline moved while stalled");

endmodule

/* rtl/world_to_screen_projection.sv */
// ----------------------------------------------------------------------------
// world_to_screen_projection: Q16.16 perspective projection to screen pixels
// An accepted transform word runs through four arithmetic stages behind the
// queue, 30 divider stages and an output register to its result word.
// Throughput: one word per cycle unless stalled; loads give no result and take one slot.
// The divider delivers one quotient bit per stage and sets the latency.
// Reset clears the matrix and queue and sets width 1920, height 1080.
// ----------------------------------------------------------------------------
module world_to_screen_projection (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  wtsp_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output wtsp_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wtsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wtsp_pkg::SCALE_W-1:0]     cfg_data
);
  import wtsp_pkg::*;

  logic [SCALE_W-1:0] width_r;
  logic [SCALE_W-1:0] height_r;
  logic               q_valid;
  logic               pop;
  front_item_t        q_item;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  wtsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  wtsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .scr_width  (width_r),
    .scr_height (height_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
